/* hdl/elka_pkg.sv */
// Shared types, constants and the control store for the echo lowest-k average filter.
// No dependencies; used by echo_lowest_k_average_filter through scoped names.
`timescale 1ns / 1ps

package elka_pkg;

   // Field widths
   localparam int unsigned ECHO_W      = 16;
   localparam int unsigned DIST_W      = 11;
   localparam int unsigned REQ_TDATA_W = 16;
   localparam int unsigned RSP_TDATA_W = 32;

   // No-object echo time after reset
   localparam logic [ECHO_W-1:0] NO_OBJECT_RESET = 16'd38000;

   // Distance scaling: cm = us * 172 / 10000
   localparam logic [7:0]  DIST_NUM = 8'd172;
   // avg * 172 stays below 2^24
   localparam int unsigned PROD_W   = 24;
   // Divide by 10000 as multiply by ceil(2^38 / 10000), exact for 24-bit products
   localparam int unsigned DIST_SHIFT  = 38;
   localparam int unsigned DIST_MUL_W  = 25;
   localparam logic [DIST_MUL_W-1:0] DIST_MUL = 25'd27487791;
   localparam int unsigned DIST_PROD_W = PROD_W + DIST_MUL_W;

   localparam int unsigned PC_W = 4;

   // Datapath operation selected by the current control word
   typedef enum logic [2:0] {
      OP_ACCEPT,
      OP_READ,
      OP_INSERT,
      OP_SUM,
      OP_AVG,
      OP_SCALE,
      OP_DIST,
      OP_EMIT
   } op_type;

   // Sequencing of the step counter
   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_HOLD_REQ,
      JMP_LOOP,
      JMP_HOLD_OUT
   } jmp_type;

   // Loop length selector
   typedef enum logic {
      LIM_SCAN,
      LIM_KEEP
   } lim_type;

   typedef struct packed {
      op_type           op;
      jmp_type          jmp;
      lim_type          lim;
      logic [PC_W-1:0]  target;
   } ucode_type;

   // Program step addresses
   localparam logic [PC_W-1:0] STEP_ACCEPT = 4'd0;
   localparam logic [PC_W-1:0] STEP_READ   = 4'd1;
   localparam logic [PC_W-1:0] STEP_INSERT = 4'd2;
   localparam logic [PC_W-1:0] STEP_SUM    = 4'd3;
   localparam logic [PC_W-1:0] STEP_AVG    = 4'd4;
   localparam logic [PC_W-1:0] STEP_SCALE  = 4'd5;
   localparam logic [PC_W-1:0] STEP_DIST   = 4'd6;
   localparam logic [PC_W-1:0] STEP_EMIT   = 4'd7;

   // Control store: one word per step
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      w = '{op: OP_ACCEPT, jmp: JMP_HOLD_REQ, lim: LIM_SCAN, target: STEP_ACCEPT};
      case (pc)
         STEP_ACCEPT: begin
            w = '{op: OP_ACCEPT, jmp: JMP_HOLD_REQ, lim: LIM_SCAN, target: STEP_ACCEPT};
         end
         STEP_READ: begin
            w = '{op: OP_READ, jmp: JMP_NEXT, lim: LIM_SCAN, target: STEP_READ};
         end
         STEP_INSERT: begin
            w = '{op: OP_INSERT, jmp: JMP_LOOP, lim: LIM_SCAN, target: STEP_READ};
         end
         STEP_SUM: begin
            w = '{op: OP_SUM, jmp: JMP_LOOP, lim: LIM_KEEP, target: STEP_SUM};
         end
         STEP_AVG: begin
            w = '{op: OP_AVG, jmp: JMP_NEXT, lim: LIM_KEEP, target: STEP_AVG};
         end
         STEP_SCALE: begin
            w = '{op: OP_SCALE, jmp: JMP_NEXT, lim: LIM_KEEP, target: STEP_SCALE};
         end
         STEP_DIST: begin
            w = '{op: OP_DIST, jmp: JMP_NEXT, lim: LIM_KEEP, target: STEP_DIST};
         end
         STEP_EMIT: begin
            w = '{op: OP_EMIT, jmp: JMP_HOLD_OUT, lim: LIM_KEEP, target: STEP_ACCEPT};
         end
         default: begin
            w = '{op: OP_ACCEPT, jmp: JMP_HOLD_REQ, lim: LIM_SCAN, target: STEP_ACCEPT};
         end
      endcase
      return w;
   endfunction

endpackage

/* hdl/echo_lowest_k_average_filter.sv */
// Echo lowest-k average filter: microcoded sequencer, echo ring memory and datapath.
// Depends on elka_pkg (types, constants, control store).
//
// Channels
//   req_*  : one echo time per transfer (req_tdata[15:0] = echo_us).
//   rsp_*  : one result per echo (rsp_tdata[15:0] = avg_echo_us,
//            rsp_tdata[26:16] = distance_cm, upper bits zero).
//   csr_*  : no-object echo time; always ready, write only while idle.
// Timing
//   After the accept step the program scans the newest min(WINDOW, BUFFER_DEPTH)
//   entries, each in a read step and an insert step into the sorted row, sums
//   KEEP_LOWEST values at one per cycle, then takes one step each for the
//   average, the scaling product and the distance (reciprocal multiplies).
//   rsp_tvalid rises when the emit step loads the output register; the next
//   echo is taken only after that, so the block works on one echo at a time.
// Reset and stalls
//   Ring entries read as 38000 until written (per-entry valid bits), the first
//   echo goes to slot 0. If the output register is still full when the next
//   result is ready, the sequencer holds in its emit step and takes no input.
`timescale 1ns / 1ps

module echo_lowest_k_average_filter #(
   parameter int unsigned BUFFER_DEPTH = 16,
   parameter int unsigned WINDOW       = 8,
   parameter int unsigned KEEP_LOWEST  = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // [15:0] echo_us
   input  logic [elka_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [15:0] avg_echo_us, [26:16] distance_cm, [31:27] zero
   output logic [elka_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [elka_pkg::ECHO_W-1:0]          csr_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready
);

   localparam int unsigned SCAN_LEN = (WINDOW < BUFFER_DEPTH) ? WINDOW : BUFFER_DEPTH;
   localparam int unsigned PTR_W    = $clog2(BUFFER_DEPTH);
   localparam int unsigned CNT_W    = (PTR_W > 6) ? PTR_W : 6;
   localparam int unsigned AW       = CNT_W + 1;
   localparam int unsigned SUM_W    = elka_pkg::ECHO_W + $clog2(KEEP_LOWEST);
   localparam int unsigned EW       = elka_pkg::ECHO_W;
   localparam int unsigned PAD_W    = elka_pkg::RSP_TDATA_W - EW - elka_pkg::DIST_W;
   localparam int unsigned PROD_W   = elka_pkg::PROD_W;
   localparam int unsigned DPROD_W  = elka_pkg::DIST_PROD_W;

   // Average as sum * ceil(2^s / KEEP_LOWEST) >> s, exact for every SUM_W-bit sum
   localparam int unsigned AVG_SHIFT  = SUM_W + $clog2(KEEP_LOWEST);
   localparam int unsigned AVG_MUL_W  = SUM_W + 1;
   localparam int unsigned AVG_PROD_W = 2 * SUM_W + 1;
   localparam logic [AVG_MUL_W-1:0] AVG_MUL =
      AVG_MUL_W'(((64'd1 << AVG_SHIFT) + 64'(KEEP_LOWEST) - 64'd1) / 64'(KEEP_LOWEST));

   // Sequencer state
   logic [elka_pkg::PC_W-1:0] pc_ff, pc_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   elka_pkg::ucode_type       uword;
   logic [CNT_W-1:0]          cnt_last;
   logic                      req_xfer;
   logic                      out_free;
   logic                      emit_go;

   // Configuration
   logic [EW-1:0]             no_obj_ff;

   // Ring storage
   logic [EW-1:0]             ring_mem [BUFFER_DEPTH];
   logic [BUFFER_DEPTH-1:0]   ring_vld_ff;
   logic [PTR_W-1:0]          newest_ff;
   logic [PTR_W-1:0]          slot_next;
   logic [PTR_W-1:0]          rd_pos;
   logic [AW-1:0]             newest_x;
   logic [AW-1:0]             cnt_x;
   logic [AW-1:0]             pos_x;
   logic [EW-1:0]             rd_data_ff;
   logic                      rd_vld_ff;

   // Sorted row of the smallest values and its insert network
   logic [EW-1:0]             low_ff [KEEP_LOWEST];
   logic [EW-1:0]             ins_row [KEEP_LOWEST];
   logic [EW-1:0]             ins_val;

   // Accumulator, reciprocal multiplies and result
   logic [SUM_W-1:0]                  acc_ff;
   logic [AVG_PROD_W-1:0]             avg_prod;
   logic [PROD_W-1:0]                 scale_prod;
   logic [DPROD_W-1:0]                dist_prod;
   logic [EW-1:0]                     avg_ff;
   logic [PROD_W-1:0]                 prod_ff;
   logic [elka_pkg::DIST_W-1:0]       dist_ff;
   logic [elka_pkg::RSP_TDATA_W-1:0]  rsp_tdata_ff;
   logic                              rsp_valid_ff;

   // Control word fetch and loop bound
   always_comb begin
      uword = elka_pkg::ucode_rom(pc_ff);
      case (uword.lim)
         elka_pkg::LIM_SCAN: cnt_last = CNT_W'(SCAN_LEN - 1);
         elka_pkg::LIM_KEEP: cnt_last = CNT_W'(KEEP_LOWEST - 1);
         default:            cnt_last = CNT_W'(KEEP_LOWEST - 1);
      endcase
   end

   assign req_tready = (uword.op == elka_pkg::OP_ACCEPT);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign emit_go    = (uword.op == elka_pkg::OP_EMIT) && out_free;
   assign csr_ready  = 1'b1;

   // Next step and loop counter
   always_comb begin
      pc_in  = pc_ff;
      cnt_in = cnt_ff;
      case (uword.jmp)
         elka_pkg::JMP_NEXT: begin
            pc_in = pc_ff + 1'b1;
         end
         elka_pkg::JMP_HOLD_REQ: begin
            if (req_xfer) begin
               pc_in  = pc_ff + 1'b1;
               cnt_in = '0;
            end
         end
         elka_pkg::JMP_LOOP: begin
            if (cnt_ff == cnt_last) begin
               pc_in  = pc_ff + 1'b1;
               cnt_in = '0;
            end else begin
               pc_in  = uword.target;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         elka_pkg::JMP_HOLD_OUT: begin
            if (out_free) begin
               pc_in = uword.target;
            end
         end
         default: begin
            pc_in  = elka_pkg::STEP_ACCEPT;
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= elka_pkg::STEP_ACCEPT;
         cnt_ff <= '0;
      end else begin
         pc_ff  <= pc_in;
         cnt_ff <= cnt_in;
      end
   end

   // No-object register
   always_ff @(posedge clock) begin
      if (reset) begin
         no_obj_ff <= elka_pkg::NO_OBJECT_RESET;
      end else if (csr_valid) begin
         no_obj_ff <= csr_data;
      end
   end

   // Ring addressing: next write slot and scan position newest - cnt
   always_comb begin
      slot_next = (newest_ff == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : newest_ff + 1'b1;
      newest_x  = AW'(newest_ff);
      cnt_x     = {1'b0, cnt_ff};
      if (cnt_x <= newest_x) begin
         pos_x = newest_x - cnt_x;
      end else begin
         pos_x = newest_x + AW'(BUFFER_DEPTH) - cnt_x;
      end
      rd_pos = pos_x[PTR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         newest_ff   <= PTR_W'(BUFFER_DEPTH - 1);
         ring_vld_ff <= '0;
      end else if (req_xfer) begin
         newest_ff              <= slot_next;
         ring_vld_ff[slot_next] <= 1'b1;
      end
   end

   // Ring memory: write on accept, registered read during the scan
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         ring_mem[slot_next] <= req_tdata[EW-1:0];
      end
      if (uword.op == elka_pkg::OP_READ) begin
         rd_data_ff <= ring_mem[rd_pos];
         rd_vld_ff  <= ring_vld_ff[rd_pos];
      end
   end

   // Insert network: each cell keeps, shifts up or takes the new value
   always_comb begin
      ins_val    = rd_vld_ff ? rd_data_ff : elka_pkg::NO_OBJECT_RESET;
      ins_row[0] = (low_ff[0] <= ins_val) ? low_ff[0] : ins_val;
      for (int j = 1; j < KEEP_LOWEST; j++) begin
         if (low_ff[j] <= ins_val) begin
            ins_row[j] = low_ff[j];
         end else if (low_ff[j-1] > ins_val) begin
            ins_row[j] = low_ff[j-1];
         end else begin
            ins_row[j] = ins_val;
         end
      end
   end

   // Sorted row: preset on accept, insert while scanning, shift out while summing
   always_ff @(posedge clock) begin
      case (uword.op)
         elka_pkg::OP_ACCEPT: begin
            if (req_xfer) begin
               for (int j = 0; j < KEEP_LOWEST; j++) begin
                  low_ff[j] <= no_obj_ff;
               end
            end
         end
         elka_pkg::OP_INSERT: begin
            for (int j = 0; j < KEEP_LOWEST; j++) begin
               low_ff[j] <= ins_row[j];
            end
         end
         elka_pkg::OP_SUM: begin
            for (int j = 0; j < KEEP_LOWEST - 1; j++) begin
               low_ff[j] <= low_ff[j+1];
            end
         end
         default: begin
         end
      endcase
   end

   // Reciprocal multiplies for the average and the distance
   always_comb begin
      avg_prod   = AVG_PROD_W'(acc_ff) * AVG_PROD_W'(AVG_MUL);
      scale_prod = PROD_W'(avg_ff) * PROD_W'(elka_pkg::DIST_NUM);
      dist_prod  = DPROD_W'(prod_ff) * DPROD_W'(elka_pkg::DIST_MUL);
   end

   // Accumulator (cleared on accept, summed while summing) and result registers, one step each
   always_ff @(posedge clock) begin
      case (uword.op)
         elka_pkg::OP_ACCEPT: begin
            acc_ff <= '0;
         end
         elka_pkg::OP_SUM: begin
            acc_ff <= acc_ff + SUM_W'(low_ff[0]);
         end
         elka_pkg::OP_AVG: begin
            avg_ff <= avg_prod[AVG_SHIFT +: EW];
         end
         elka_pkg::OP_SCALE: begin
            prod_ff <= scale_prod;
         end
         elka_pkg::OP_DIST: begin
            dist_ff <= dist_prod[elka_pkg::DIST_SHIFT +: elka_pkg::DIST_W];
         end
         default: begin
         end
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_tdata_ff <= {{PAD_W{1'b0}}, dist_ff, avg_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

/* verif/echo_lowest_k_average_filter_tb.sv */
// Self-checking testbench for the echo lowest-k average filter.
// Depends on elka_pkg and echo_lowest_k_average_filter; no files or arguments read.
`timescale 1ns / 1ps

module echo_lowest_k_average_filter_tb;

   // Block configuration, kept in step with the instance below
   localparam int unsigned DEPTH      = 16;
   localparam int unsigned WINDOW_LEN = 8;
   localparam int unsigned KEEP       = 4;
   localparam int unsigned SCAN_LEN   = (WINDOW_LEN < DEPTH) ? WINDOW_LEN : DEPTH;
   localparam int unsigned LATENCY    = 2 * SCAN_LEN + KEEP + 5;
   localparam int unsigned SETTLE     = 2 * LATENCY;

   localparam int unsigned EW = elka_pkg::ECHO_W;
   localparam int unsigned DW = elka_pkg::DIST_W;

   // cm = us * 172 / 10000
   localparam logic [31:0] CM_SCALE_NUM = 32'd172;
   localparam logic [31:0] CM_SCALE_DEN = 32'd10000;

   localparam int unsigned ITEMS_PER_PHASE = 105;
   localparam int unsigned PHASES          = 6;
   localparam int unsigned HOLD_OFF_CYCLES = 600;
   localparam int unsigned HOLD_OFF_AFTER  = 150;
   localparam int unsigned QUIET_LIMIT     = 5000;
   localparam int unsigned DIRECTED_ROWS   = 21;

   typedef struct packed {
      logic [EW-1:0] avg_echo_us;
      logic [DW-1:0] distance_cm;
   } echo_result_type;

   // One directed echo; known marks a result typed in by hand
   typedef struct packed {
      logic [EW-1:0] echo_us;
      logic          known;
      logic [EW-1:0] avg_echo_us;
      logic [DW-1:0] distance_cm;
   } echo_row_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic [elka_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [elka_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [EW-1:0]                    csr_data = elka_pkg::NO_OBJECT_RESET;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;

   // Shadow of the block state for prediction
   logic [EW-1:0] echo_window [DEPTH];
   int unsigned   window_head;
   logic [EW-1:0] blank_echo;

   echo_result_type awaited_results [$];
   int unsigned  echoes_sent;
   int unsigned  results_seen;
   int unsigned  fault_count;
   int unsigned  quiet_cycles;
   int unsigned  burst_left;
   int unsigned  settings_used;
   logic [EW-1:0] last_echo;
   bit           hold_off_done;

   // Directed echoes: padding after reset, extremes, ties around the no-object value
   echo_row_type directed_rows [DIRECTED_ROWS] = '{
      '{16'd0,      1'b1, 16'd28500, 11'd490},
      '{16'd65535,  1'b1, 16'd28500, 11'd490},
      '{16'd1,      1'b0, 16'd0,     11'd0},
      '{16'd2,      1'b0, 16'd0,     11'd0},
      '{16'd3,      1'b1, 16'd1,     11'd0},
      '{16'd65535,  1'b0, 16'd0,     11'd0},
      '{16'd65535,  1'b0, 16'd0,     11'd0},
      '{16'd65535,  1'b0, 16'd0,     11'd0},
      '{16'd65535,  1'b0, 16'd0,     11'd0},
      '{16'd65535,  1'b0, 16'd0,     11'd0},
      '{16'd65535,  1'b0, 16'd0,     11'd0},
      '{16'd65535,  1'b0, 16'd0,     11'd0},
      '{16'd65535,  1'b1, 16'd38000, 11'd653},
      '{16'd37999,  1'b0, 16'd0,     11'd0},
      '{16'd38000,  1'b0, 16'd0,     11'd0},
      '{16'd38001,  1'b0, 16'd0,     11'd0},
      '{16'd12345,  1'b0, 16'd0,     11'd0},
      '{16'h5555,   1'b0, 16'd0,     11'd0},
      '{16'hAAAA,   1'b0, 16'd0,     11'd0},
      '{16'h8000,   1'b0, 16'd0,     11'd0},
      '{16'h7FFF,   1'b0, 16'd0,     11'd0}
   };

   echo_lowest_k_average_filter #(
      .BUFFER_DEPTH(DEPTH),
      .WINDOW      (WINDOW_LEN),
      .KEEP_LOWEST (KEEP)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_data  (csr_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Store the echo, take the lowest KEEP of the newest window, average and scale
   function automatic echo_result_type lowest_k_average(input logic [EW-1:0] echo);
      logic [EW-1:0]     kept [KEEP];
      logic [EW-1:0]     v;
      int unsigned       slot;
      int unsigned       j;
      logic [31:0]       total;
      logic [31:0]       mean;
      logic [31:0]       scaled;
      echo_result_type   r;
      window_head = (window_head + 1) % DEPTH;
      echo_window[window_head] = echo;
      for (int unsigned i = 0; i < KEEP; i++) kept[i] = blank_echo;
      for (int unsigned i = 0; i < SCAN_LEN; i++) begin
         slot = (window_head + DEPTH - i) % DEPTH;
         v = echo_window[slot];
         if (v < kept[KEEP-1]) begin
            j = KEEP - 1;
            while (j > 0 && kept[j-1] > v) begin
               kept[j] = kept[j-1];
               j--;
            end
            kept[j] = v;
         end
      end
      total = '0;
      for (int unsigned i = 0; i < KEEP; i++) total += 32'(kept[i]);
      mean = total / KEEP;
      scaled = (mean * CM_SCALE_NUM) / CM_SCALE_DEN;
      r.avg_echo_us = mean[EW-1:0];
      r.distance_cm = scaled[DW-1:0];
      return r;
   endfunction

   // Random echo: wide values, values near the no-object time, small ones, zero, all ones, repeats
   function automatic logic [EW-1:0] pick_echo();
      int          near;
      int unsigned kind;
      kind = $urandom_range(0, 19);
      if (kind <= 7) return EW'($urandom_range(0, 65535));
      if (kind <= 10) begin
         near = int'(blank_echo) + int'($urandom_range(0, 64)) - 32;
         if (near < 0) near = 0;
         if (near > 65535) near = 65535;
         return EW'(near);
      end
      if (kind <= 13) return EW'($urandom_range(0, 300));
      if (kind == 14) return '0;
      if (kind == 15) return '1;
      if (kind <= 17) return last_echo;
      return last_echo ^ EW'($urandom_range(0, 15));
   endfunction

   task automatic report_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) $display("%t ERROR %s", $realtime, msg);
   endtask

   // Offer one echo in bursts with random gaps; predict at the transfer
   task automatic send_echo(input echo_row_type row);
      int unsigned     gap;
      echo_result_type want;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= row.echo_us;
      do @(posedge clock); while (!req_tready);
      want = lowest_k_average(row.echo_us);
      if (row.known) begin
         want.avg_echo_us = row.avg_echo_us;
         want.distance_cm = row.distance_cm;
      end
      awaited_results.push_back(want);
      last_echo = row.echo_us;
      burst_left--;
      echoes_sent++;
   endtask

   // Wait for the last result, then let the sequencer come back to rest
   task automatic wait_idle();
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_blank_echo(input logic [EW-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      blank_echo = value;
      settings_used++;
      csr_valid <= 1'b0;
   endtask

   // Result check against the oldest expectation
   always @(posedge clock) begin : result_check
      echo_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (awaited_results.size() == 0) begin
            report_fault($sformatf("result with nothing awaited: tdata=%h", rsp_tdata));
         end else begin
            want = awaited_results.pop_front();
            if (rsp_tdata[15:0] !== want.avg_echo_us)
               report_fault($sformatf("avg_echo_us exp %0d got %0d",
                                      want.avg_echo_us, rsp_tdata[15:0]));
            if (rsp_tdata[26:16] !== want.distance_cm)
               report_fault($sformatf("distance_cm exp %0d got %0d",
                                      want.distance_cm, rsp_tdata[26:16]));
            if (rsp_tdata[31:27] !== '0)
               report_fault($sformatf("padding exp 0 got %h", rsp_tdata[31:27]));
         end
      end
   end

   // Receiver: stall pattern picked at random from four modes, one long hold-off
   initial begin : receiver
      int unsigned mode;
      int unsigned tick;
      mode = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         if (!hold_off_done && results_seen >= HOLD_OFF_AFTER) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_done = 1'b1;
         end else begin
            if (tick % 50 == 0) mode = $urandom_range(0, 3);
            tick++;
            case (mode)
               0: begin
                  rsp_tready <= 1'b1;
               end
               1: begin
                  rsp_tready <= 1'($urandom_range(0, 1));
               end
               2: begin
                  rsp_tready <= ($urandom_range(0, 3) == 0);
               end
               default: begin
                  rsp_tready <= tick[0];
               end
            endcase
         end
      end
   end

   // Watchdog: count cycles with no transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Main sequence
   initial begin : stimulus
      logic [EW-1:0] settings [PHASES];
      echo_row_type  row;
      for (int unsigned i = 0; i < DEPTH; i++) echo_window[i] = elka_pkg::NO_OBJECT_RESET;
      window_head   = DEPTH - 1;
      blank_echo    = elka_pkg::NO_OBJECT_RESET;
      last_echo     = '0;
      hold_off_done = 1'b0;
      settings[0] = 16'hFFFF;
      settings[1] = 16'h0000;
      settings[2] = EW'($urandom_range(0, 65535));
      settings[3] = 16'd1;
      settings[4] = EW'($urandom_range(100, 60000));
      settings[5] = elka_pkg::NO_OBJECT_RESET;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) send_echo(directed_rows[i]);
      req_tvalid <= 1'b0;

      for (int unsigned p = 0; p < PHASES; p++) begin
         wait_idle();
         write_blank_echo(settings[p]);
         for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
            row = '0;
            row.echo_us = pick_echo();
            send_echo(row);
         end
         req_tvalid <= 1'b0;
      end

      wait_idle();
      if (awaited_results.size() != 0)
         report_fault($sformatf("%0d results never arrived", awaited_results.size()));
      $display("Run: %0d echoes, %0d results, %0d no-object settings, %0d faults.",
               echoes_sent, results_seen, settings_used + 1, fault_count);
      $display("Included zero and full-scale no-object values and a %0d-cycle output hold-off.",
               HOLD_OFF_CYCLES);
      if (fault_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/elka_pkg.sv
hdl/echo_lowest_k_average_filter.sv
verif/echo_lowest_k_average_filter_tb.sv
